[design/p2d_pkg.sv]
// ----------------------------------------------------------------------------
// p2d_pkg
// Shared types, register indexes and default sizes for the 2D pooling block.
// ----------------------------------------------------------------------------
package p2d_pkg;

   localparam int unsigned MAX_COLS_DEF    = 1024;
   localparam int unsigned MAX_WIN_DEF     = 8;
   localparam int unsigned SAMPLE_BITS_DEF = 16;

   localparam int unsigned MAP_BITS       = 11;
   localparam int unsigned WIN_CFG_BITS   = 4;
   localparam int unsigned CSR_DATA_BITS  = 11;
   localparam int unsigned CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MAP_ROWS  = 3'd0,
      REG_MAP_COLS  = 3'd1,
      REG_WIN_ROWS  = 3'd2,
      REG_WIN_COLS  = 3'd3,
      REG_POOL_MODE = 3'd4
   } p2d_reg_type;

   localparam logic MODE_MAX = 1'b0;
   localparam logic MODE_AVG = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_FOLD,
      ST_DIV,
      ST_EMIT
   } p2d_state_type;

endpackage

[design/p2d_if.sv]
// ----------------------------------------------------------------------------
// p2d_if
// Valid/ready channels for pooling samples in and pooled results out.
// ----------------------------------------------------------------------------
interface p2d_req_if import p2d_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

interface p2d_rsp_if import p2d_pkg::*; #(
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pooled_value;
   logic                          map_done;

   modport source (output valid, output pooled_value, output map_done, input ready);
   modport sink   (input valid, input pooled_value, input map_done, output ready);
endinterface

[design/p2d_ram.sv]
// ----------------------------------------------------------------------------
// p2d_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module p2d_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pool2d_forward_max_avg.sv]
// ----------------------------------------------------------------------------
// pool2d_forward_max_avg
// Non-overlapping 2D max / average pooling over raster-ordered feature maps,
// with partial edge windows and a line store of column partials.
//
//  channel  dir  handshake              payload
//  req_bus  in   valid/ready            sample_value
//  rsp_bus  out  valid/ready            pooled_value, map_done
//  csr_*    in   csr_we                 csr_index, csr_wdata
//
// Ready only in the idle step; no new sample is taken until the last is
// through. A sample passes the accumulate step, then at a segment end the
// fold step, at a max window end the emit step, at an average window end
// the one-bit-per-cycle divider and then emit; the shared max/add unit
// serves accumulate and fold. Synchronous reset clears control state; the
// line store needs no clearing. A full result register stalls emit only.
// ----------------------------------------------------------------------------
module pool2d_forward_max_avg import p2d_pkg::*; #(
   parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
   parameter int unsigned MAX_WIN     = MAX_WIN_DEF,
   parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   p2d_req_if.sink                   req_bus,
   p2d_rsp_if.source                 rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned WIN_BITS  = $clog2(MAX_WIN + 1);
   localparam int unsigned CELL_BITS = 2 * WIN_BITS;
   localparam int unsigned PART_BITS = SAMPLE_BITS + CELL_BITS;
   localparam int unsigned POS_BITS  = $clog2(MAX_COLS + 1);
   localparam int unsigned ADDR_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned CMP_BITS  = ((POS_BITS > MAP_BITS) ? POS_BITS : MAP_BITS) + 1;
   localparam int unsigned CMPW_BITS =
      ((WIN_BITS > WIN_CFG_BITS) ? WIN_BITS : WIN_CFG_BITS) + 1;
   localparam int unsigned DCNT_BITS = $clog2(PART_BITS + 1);

   p2d_state_type state_ff, state_in;

   logic [MAP_BITS-1:0]     map_rows_ff, map_rows_in, map_cols_ff, map_cols_in;
   logic [WIN_CFG_BITS-1:0] win_rows_ff, win_rows_in, win_cols_ff, win_cols_in;
   logic                    pool_mode_ff, pool_mode_in;

   logic [POS_BITS-1:0]     row_pos_ff, row_pos_in, col_pos_ff, col_pos_in;
   logic [WIN_BITS-1:0]     riw_ff, riw_in, ciw_ff, ciw_in;
   logic [ADDR_BITS-1:0]    win_idx_ff, win_idx_in;
   logic signed [PART_BITS-1:0] rp_ff, rp_in;

   logic signed [PART_BITS-1:0] smp_ff, smp_in;
   logic [WIN_BITS-1:0]     it_riw_ff, it_riw_in, it_ciw_ff, it_ciw_in;
   logic                    it_seg_end_ff, it_seg_end_in;
   logic                    it_win_end_ff, it_win_end_in;
   logic                    it_done_ff, it_done_in;
   logic [ADDR_BITS-1:0]    it_slot_ff, it_slot_in;

   logic signed [PART_BITS-1:0] acc_ff, acc_in;
   logic [CELL_BITS-1:0]    cells_ff, cells_in;
   logic [CELL_BITS-1:0]    div_rem_ff, div_rem_in;
   logic [PART_BITS-1:0]    div_quo_ff, div_quo_in;
   logic [DCNT_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic                    div_neg_ff, div_neg_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic                    req_acc;
   logic                    last_col, last_row, seg_end, win_end;
   logic                    cfg_hit;
   logic signed [PART_BITS-1:0] alu_a, alu_b, alu_y, fold_p, res_wide;
   logic [CELL_BITS:0]      div_shift, div_diff;
   logic                    div_ge;
   logic [PART_BITS-1:0]    ram_rdata;
   logic                    ram_we, ram_re;
   logic [MAP_BITS-1:0]     csr_map;
   logic [WIN_CFG_BITS-1:0] csr_win;
   logic [MAP_BITS-1:0]     map_clamped;
   logic [WIN_CFG_BITS-1:0] win_clamped;

   p2d_ram #(
      .WIDTH (PART_BITS),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (it_slot_ff),
      .wr_data (fold_p),
      .rd_en   (ram_re),
      .rd_addr (win_idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_acc  = req_bus.valid && (state_ff == ST_IDLE);
   assign ram_re   = req_acc;
   assign ram_we   = (state_ff == ST_FOLD);

   assign last_col = (CMP_BITS'(col_pos_ff) + CMP_BITS'(1)) >= CMP_BITS'(map_cols_ff);
   assign last_row = (CMP_BITS'(row_pos_ff) + CMP_BITS'(1)) >= CMP_BITS'(map_rows_ff);
   assign seg_end  = last_col ||
      ((CMPW_BITS'(ciw_ff) + CMPW_BITS'(1)) >= CMPW_BITS'(win_cols_ff));
   assign win_end  = last_row ||
      ((CMPW_BITS'(riw_ff) + CMPW_BITS'(1)) >= CMPW_BITS'(win_rows_ff));

   assign csr_map = csr_wdata[MAP_BITS-1:0];
   assign csr_win = csr_wdata[WIN_CFG_BITS-1:0];
   assign map_clamped = (csr_map == '0) ? MAP_BITS'(1) :
                        (32'(csr_map) > 32'(MAX_COLS)) ? MAP_BITS'(MAX_COLS) : csr_map;
   assign win_clamped = (csr_win == '0) ? WIN_CFG_BITS'(1) :
                        (32'(csr_win) > 32'(MAX_WIN)) ? WIN_CFG_BITS'(MAX_WIN) : csr_win;

   // shared max / add unit
   assign alu_a = (state_ff == ST_FOLD) ? $signed(ram_rdata) : rp_ff;
   assign alu_b = (state_ff == ST_FOLD) ? rp_ff : smp_ff;
   assign alu_y = (pool_mode_ff == MODE_AVG) ? (alu_a + alu_b) :
                  ((alu_b > alu_a) ? alu_b : alu_a);
   assign fold_p = (it_riw_ff == '0) ? rp_ff : alu_y;

   assign div_shift = {div_rem_ff, div_quo_ff[PART_BITS-1]};
   assign div_diff  = div_shift - {1'b0, cells_ff};
   assign div_ge    = (div_shift >= {1'b0, cells_ff});

   assign res_wide = (pool_mode_ff == MODE_AVG) ?
                     (div_neg_ff ? -$signed(div_quo_ff) : $signed(div_quo_ff)) : acc_ff;

   always_comb begin
      state_in      = state_ff;
      map_rows_in   = map_rows_ff;
      map_cols_in   = map_cols_ff;
      win_rows_in   = win_rows_ff;
      win_cols_in   = win_cols_ff;
      pool_mode_in  = pool_mode_ff;
      row_pos_in    = row_pos_ff;
      col_pos_in    = col_pos_ff;
      riw_in        = riw_ff;
      ciw_in        = ciw_ff;
      win_idx_in    = win_idx_ff;
      rp_in         = rp_ff;
      smp_in        = smp_ff;
      it_riw_in     = it_riw_ff;
      it_ciw_in     = it_ciw_ff;
      it_seg_end_in = it_seg_end_ff;
      it_win_end_in = it_win_end_ff;
      it_done_in    = it_done_ff;
      it_slot_in    = it_slot_ff;
      acc_in        = acc_ff;
      cells_in      = cells_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      div_neg_in    = div_neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_done_in   = rsp_done_ff;
      cfg_hit       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               smp_in        = PART_BITS'(req_bus.sample_value);
               it_riw_in     = riw_ff;
               it_ciw_in     = ciw_ff;
               it_seg_end_in = seg_end;
               it_win_end_in = win_end;
               it_done_in    = last_col && last_row;
               it_slot_in    = win_idx_ff;
               if (last_col) begin
                  col_pos_in = '0;
                  ciw_in     = '0;
                  win_idx_in = '0;
                  if (last_row) begin
                     row_pos_in = '0;
                     riw_in     = '0;
                  end else begin
                     row_pos_in = row_pos_ff + POS_BITS'(1);
                     riw_in     = win_end ? '0 : riw_ff + WIN_BITS'(1);
                  end
               end else begin
                  col_pos_in = col_pos_ff + POS_BITS'(1);
                  ciw_in     = seg_end ? '0 : ciw_ff + WIN_BITS'(1);
                  win_idx_in = seg_end ? win_idx_ff + ADDR_BITS'(1) : win_idx_ff;
               end
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            rp_in    = (it_ciw_ff == '0) ? smp_ff : alu_y;
            state_in = it_seg_end_ff ? ST_FOLD : ST_IDLE;
         end
         ST_FOLD: begin
            acc_in     = fold_p;
            cells_in   = (CELL_BITS'(it_riw_ff) + CELL_BITS'(1)) *
                         (CELL_BITS'(it_ciw_ff) + CELL_BITS'(1));
            div_neg_in = fold_p[PART_BITS-1];
            div_quo_in = fold_p[PART_BITS-1] ? PART_BITS'(-fold_p) : PART_BITS'(fold_p);
            div_rem_in = '0;
            div_cnt_in = DCNT_BITS'(PART_BITS);
            if (!it_win_end_ff) begin
               state_in = ST_IDLE;
            end else if (pool_mode_ff == MODE_AVG) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_diff[CELL_BITS-1:0] : div_shift[CELL_BITS-1:0];
            div_quo_in = {div_quo_ff[PART_BITS-2:0], div_ge};
            div_cnt_in = div_cnt_ff - DCNT_BITS'(1);
            if (div_cnt_ff == DCNT_BITS'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_wide[SAMPLE_BITS-1:0];
               rsp_done_in  = it_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         cfg_hit = 1'b1;
         unique case (csr_index)
            REG_MAP_ROWS:  map_rows_in  = map_clamped;
            REG_MAP_COLS:  map_cols_in  = map_clamped;
            REG_WIN_ROWS:  win_rows_in  = win_clamped;
            REG_WIN_COLS:  win_cols_in  = win_clamped;
            REG_POOL_MODE: pool_mode_in = csr_wdata[0];
            default:       cfg_hit      = 1'b0;
         endcase
         if (cfg_hit) begin
            row_pos_in = '0;
            col_pos_in = '0;
            riw_in     = '0;
            ciw_in     = '0;
            win_idx_in = '0;
            rp_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_rows_ff  <= MAP_BITS'(1);
         map_cols_ff  <= MAP_BITS'(1);
         win_rows_ff  <= WIN_CFG_BITS'(2);
         win_cols_ff  <= WIN_CFG_BITS'(2);
         pool_mode_ff <= MODE_MAX;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         riw_ff       <= '0;
         ciw_ff       <= '0;
         win_idx_ff   <= '0;
         rp_ff        <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_rows_ff  <= map_rows_in;
         map_cols_ff  <= map_cols_in;
         win_rows_ff  <= win_rows_in;
         win_cols_ff  <= win_cols_in;
         pool_mode_ff <= pool_mode_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         riw_ff       <= riw_in;
         ciw_ff       <= ciw_in;
         win_idx_ff   <= win_idx_in;
         rp_ff        <= rp_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff        <= smp_in;
      it_riw_ff     <= it_riw_in;
      it_ciw_ff     <= it_ciw_in;
      it_seg_end_ff <= it_seg_end_in;
      it_win_end_ff <= it_win_end_in;
      it_done_ff    <= it_done_in;
      it_slot_ff    <= it_slot_in;
      acc_ff        <= acc_in;
      cells_ff      <= cells_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_neg_ff    <= div_neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pooled_value = rsp_value_ff;
   assign rsp_bus.map_done     = rsp_done_ff;

   a_col_in_map: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(col_pos_ff) < CMP_BITS'(map_cols_ff))
      else $error("column position beyond map width");

   a_row_in_map: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(row_pos_ff) < CMP_BITS'(map_rows_ff))
      else $error("row position beyond map height");

   a_ciw_in_win: assert property (@(posedge clock) disable iff (reset)
      CMPW_BITS'(ciw_ff) < CMPW_BITS'(win_cols_ff))
      else $error("column in window beyond window width");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < cells_ff))
      else $error("divider remainder not below cell count");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == REG_MAP_ROWS || csr_index == REG_MAP_COLS ||
                  csr_index == REG_WIN_ROWS || csr_index == REG_WIN_COLS ||
                  csr_index == REG_POOL_MODE))
      |=> (row_pos_ff == '0 && col_pos_ff == '0 && win_idx_ff == '0))
      else $error("register write did not restart the map");

endmodule
